// ----- rtl/plt_pkg.sv -----
`default_nettype none

package plt_pkg;

    localparam int PLT_TABLE_DEPTH = 256;
    localparam int PLT_PADDR_W     = 3;
    localparam int PLT_ENTRIES_W   = 9;

    // register index is the word address bit of paddr
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STAT_INTERP = 2'd0,
        STAT_FIRST  = 2'd1,
        STAT_LAST   = 2'd2,
        STAT_EMPTY  = 2'd3
    } plt_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_SEARCH,
        ST_PROBE,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_ADJ,
        ST_EMIT
    } plt_state_t;

    typedef struct packed {
        logic [31:0] etime;
        logic [31:0] evalue;
    } plt_entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } plt_mem_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/plt_req_if.sv -----
`default_nettype none

interface plt_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         entry_index;
    logic signed [31:0] entry_time;
    logic [31:0]        entry_value;
    logic signed [31:0] query_time;

    modport source (
        output valid, opcode, entry_index, entry_time, entry_value, query_time,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, entry_time, entry_value, query_time,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/plt_rsp_if.sv -----
`default_nettype none

interface plt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [1:0]  status;

    modport source (
        output valid, value, status,
        input  ready
    );
    modport sink (
        input  valid, value, status,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/plt_mem.sv -----
`default_nettype none

module plt_mem
    import plt_pkg::*;
#(
    parameter int DEPTH = PLT_TABLE_DEPTH
)
(
    input  wire logic                       clk,
    input  wire plt_mem_cmd_t               cmd,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire plt_entry_t                 wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output plt_entry_t                      rd_data
);

    plt_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/plt_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle; quotient must fit 32 bits
module plt_div
    import plt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [31:0]      rem_reg;
    logic [31:0]      quo_reg;
    logic [31:0]      dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[63:32];
            quo_reg <= dividend[31:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/piecewise_linear_table_interp_core.sv -----
`default_nettype none

// channel  | dir | handshake    | payload
// ---------+-----+--------------+----------------------------------------------------
// req      | in  | valid/ready  | opcode, entry_index, entry_time, entry_value, query_time
// rsp      | out | valid/ready  | value, status
// apb      | in  | psel/penable | entries_in_use at byte address 0
//
// write item: stored in the table at acceptance when its index is within the table depth
// query item: an empty table is answered directly, a query at or outside the first
//   or last time is clamped to that end's value, otherwise a binary search over the
//   single table read port (a read and a probe state per step) and the serial divider run
// one item at a time; a finished result waits in the output register, so the
//   next item is taken while it is still unread
// reset clears control state and entries_in_use; table contents are not cleared
module piecewise_linear_table_interp_core
    import plt_pkg::*;
#(
    parameter int TABLE_DEPTH = PLT_TABLE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PLT_PADDR_W-1:0] paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // item channels
    plt_req_if.sink                     req,
    plt_rsp_if.source                   rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // configuration register
    logic [PLT_ENTRIES_W-1:0] entries_reg;
    logic                     reg_idx;
    logic                     cfg_wr;

    // control
    plt_state_t   state_reg;
    plt_state_t   state_next;
    plt_mem_cmd_t mem_cmd;
    logic [AW-1:0] rd_addr;
    logic          div_start;
    logic          div_done;
    logic [31:0]   quotient;
    logic          load_out;
    logic          accept;
    logic          idx_ok;

    // query datapath
    logic signed [31:0] q_reg;
    logic [AW-1:0]      last_reg;
    logic [AW-1:0]      lo_reg;
    logic [AW-1:0]      hi_reg;
    logic [AW-1:0]      mid_reg;
    plt_entry_t         lo_ent_reg;
    plt_entry_t         hi_ent_reg;
    logic [63:0]        prod_reg;
    logic               down_reg;
    logic [31:0]        res_val_reg;
    plt_status_t        res_stat_reg;

    plt_entry_t         rd_data;
    plt_entry_t         wr_data;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      n_last;
    logic [AW-1:0]      span;
    logic [AW-1:0]      mid_calc;
    logic signed [31:0] rd_t;
    logic [32:0]        dq_wide;
    logic [32:0]        dt_wide;
    logic [31:0]        dv;
    logic               down_calc;

    // output register
    logic              out_valid_reg;
    logic [31:0]       out_value_reg;
    plt_status_t       out_status_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_wr && (reg_idx == REG_ENTRIES_IN_USE))
        begin
            entries_reg <= pwdata[PLT_ENTRIES_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_ENTRIES_IN_USE)
        begin
            prdata = 32'(entries_reg);
        end
    end

    // ---------------- table memory ----------------
    assign accept  = req.valid && req.ready;
    assign idx_ok  = (32'(req.entry_index) < 32'(TABLE_DEPTH));
    assign wr_addr = AW'(req.entry_index);
    assign wr_data = '{etime: req.entry_time, evalue: req.entry_value};

    plt_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .cmd     (mem_cmd),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------- serial divider ----------------
    plt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dt_wide[31:0]),
        .done     (div_done),
        .quotient (quotient)
    );

    // ---------------- datapath helpers ----------------
    always_comb
    begin
        // entries beyond the table depth count as a full table
        if (32'(entries_reg) > 32'(TABLE_DEPTH))
        begin
            n_last = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            n_last = AW'(32'(entries_reg) - 32'd1);
        end
        span      = hi_reg - lo_reg;
        mid_calc  = lo_reg + (span >> 1);
        rd_t      = $signed(rd_data.etime);
        // search keeps t0 <= q < t1, so both differences fit 32 unsigned bits
        dq_wide   = {q_reg[31], q_reg} - {lo_ent_reg.etime[31], lo_ent_reg.etime};
        dt_wide   = {hi_ent_reg.etime[31], hi_ent_reg.etime}
                  - {lo_ent_reg.etime[31], lo_ent_reg.etime};
        down_calc = (hi_ent_reg.evalue < lo_ent_reg.evalue);
        dv        = down_calc ? (lo_ent_reg.evalue - hi_ent_reg.evalue)
                              : (hi_ent_reg.evalue - lo_ent_reg.evalue);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mem_cmd    = '0;
        rd_addr    = '0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        req.ready  = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.opcode == OP_QUERY)
                    begin
                        if (entries_reg == '0)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            mem_cmd.rd_en = 1'b1;
                            rd_addr       = '0;
                            state_next    = ST_RD_FIRST;
                        end
                    end
                    else
                    begin
                        mem_cmd.wr_en = idx_ok;
                    end
                end
            end
            ST_RD_FIRST:
            begin
                // at or below the first time: clamp to first value
                if (q_reg <= rd_t)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_cmd.rd_en = 1'b1;
                    rd_addr       = last_reg;
                    state_next    = ST_RD_LAST;
                end
            end
            ST_RD_LAST:
            begin
                // at or above the last time: clamp to last value
                if (q_reg >= rd_t)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (span > AW'(1))
                begin
                    mem_cmd.rd_en = 1'b1;
                    rd_addr       = mid_calc;
                    state_next    = ST_PROBE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_PROBE:
            begin
                state_next = ST_SEARCH;
            end
            ST_MUL:
            begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // query datapath registers, updated by the sequencer state
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.opcode == OP_QUERY))
                begin
                    q_reg        <= req.query_time;
                    last_reg     <= n_last;
                    res_val_reg  <= '0;
                    res_stat_reg <= STAT_EMPTY;
                end
            end
            ST_RD_FIRST:
            begin
                lo_ent_reg   <= rd_data;
                lo_reg       <= '0;
                res_val_reg  <= rd_data.evalue;
                res_stat_reg <= STAT_FIRST;
            end
            ST_RD_LAST:
            begin
                hi_ent_reg   <= rd_data;
                hi_reg       <= last_reg;
                res_val_reg  <= rd_data.evalue;
                res_stat_reg <= STAT_LAST;
            end
            ST_SEARCH:
            begin
                mid_reg <= mid_calc;
            end
            ST_PROBE:
            begin
                if (rd_t <= q_reg)
                begin
                    lo_reg     <= mid_reg;
                    lo_ent_reg <= rd_data;
                end
                else
                begin
                    hi_reg     <= mid_reg;
                    hi_ent_reg <= rd_data;
                end
            end
            ST_MUL:
            begin
                prod_reg <= 64'(dq_wide[31:0]) * 64'(dv);
                down_reg <= down_calc;
            end
            ST_ADJ:
            begin
                res_val_reg  <= down_reg ? (lo_ent_reg.evalue - quotient)
                                         : (lo_ent_reg.evalue + quotient);
                res_stat_reg <= STAT_INTERP;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg  <= res_val_reg;
            out_status_reg <= res_stat_reg;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.status = out_status_reg;

    // ---------------- assertions ----------------
    // search bracket stays ordered and around the query time
    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |->
            (lo_reg < hi_reg) && ($signed(lo_ent_reg.etime) <= q_reg)
            && (q_reg < $signed(hi_ent_reg.etime)))
        else $error("search bracket lost");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside wait state");

    // interpolated result lies between the two bracketing values
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADJ) |=>
            (((res_val_reg >= lo_ent_reg.evalue) && (res_val_reg <= hi_ent_reg.evalue))
            || ((res_val_reg <= lo_ent_reg.evalue) && (res_val_reg >= hi_ent_reg.evalue))))
        else $error("interpolated value out of segment");

    // empty table answers with zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == STAT_EMPTY)) |-> (out_value_reg == '0))
        else $error("empty-table result not zero");

endmodule

`default_nettype wire
